// ===== src/ppm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types and constants for the pad poll master.
// ----------------------------------------------------------------------------
package ppm_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_SETUP = 2'd1;

	localparam logic [CFG_DATA_W-1:0] TICKS_RESET = 8'd100;

	localparam logic [2:0] LAST_BYTE = 3'd4;
	localparam logic [2:0] TYPE_BYTE = 3'd1;
	localparam logic [2:0] LOW_BTN_BYTE = 3'd3;

	typedef struct packed {
		logic start_poll;
		logic data_level;
	} tick_item_t;

	typedef struct packed {
		logic        clock_level;
		logic        command_level;
		logic        attention_level;
		logic        busy_res;
		logic        poll_done;
		logic [15:0] button_word;
		logic [7:0]  pad_type;
	} report_item_t;

	function automatic logic [7:0] tx_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h01;
			3'd1:    b = 8'h42;
			default: b = 8'hFF;
		endcase
		return b;
	endfunction

endpackage

// ===== src/ppm_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_chan_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface ppm_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ppm_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_seq
// Tick sequencer: attention, per-byte setup, bit clocking, reply capture.
// ----------------------------------------------------------------------------
module ppm_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  ppm_pkg::tick_item_t   tick,
	input  logic [7:0]            half_ticks,
	input  logic [7:0]            setup_ticks,
	output ppm_pkg::report_item_t res
);
	import ppm_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SETUP,
		PH_CMD,
		PH_LOW
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  byte_q, byte_d;
	logic [2:0]  bit_q, bit_d;
	logic [7:0]  wait_q, wait_d;
	logic [7:0]  tx_q, tx_d;
	logic [7:0]  rx_q, rx_d;
	logic [7:0]  lowbtn_q, lowbtn_d;
	logic [15:0] btn_q, btn_d;
	logic [7:0]  type_q, type_d;
	logic        clk_q, clk_d;
	logic        cmd_q, cmd_d;
	logic        att_q, att_d;
	logic        done;
	logic [7:0]  wait_inc;
	logic [7:0]  limit;
	logic        over;
	logic [7:0]  rx_new;

	assign wait_inc = wait_q + 8'd1;
	assign limit    = (phase_q == PH_SETUP) ? setup_ticks : half_ticks;
	assign over     = (wait_inc >= limit) || (wait_inc == 8'd0);
	assign rx_new   = {tick.data_level, rx_q[7:1]};

	always_comb begin
		phase_d  = phase_q;
		byte_d   = byte_q;
		bit_d    = bit_q;
		wait_d   = wait_q;
		tx_d     = tx_q;
		rx_d     = rx_q;
		lowbtn_d = lowbtn_q;
		btn_d    = btn_q;
		type_d   = type_q;
		clk_d    = clk_q;
		cmd_d    = cmd_q;
		att_d    = att_q;
		done     = 1'b0;
		case (phase_q)
			PH_SETUP: begin
				wait_d = wait_inc;
				if (over) begin
					cmd_d   = tx_q[0];
					wait_d  = 8'd0;
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				wait_d = wait_inc;
				if (over) begin
					clk_d   = 1'b0;
					wait_d  = 8'd0;
					phase_d = PH_LOW;
				end
			end
			PH_LOW: begin
				wait_d = wait_inc;
				if (over) begin
					clk_d  = 1'b1;
					rx_d   = rx_new;
					tx_d   = {1'b0, tx_q[7:1]};
					wait_d = 8'd0;
					if (bit_q == 3'd7) begin
						bit_d = 3'd0;
						if (byte_q == TYPE_BYTE)
							type_d = rx_new;
						if (byte_q == LOW_BTN_BYTE)
							lowbtn_d = rx_new;
						if (byte_q >= LAST_BYTE) begin
							btn_d   = {rx_new, lowbtn_q};
							att_d   = 1'b1;
							cmd_d   = 1'b1;
							byte_d  = 3'd0;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							byte_d  = byte_q + 3'd1;
							tx_d    = tx_byte(byte_q + 3'd1);
							phase_d = PH_SETUP;
						end
					end else begin
						bit_d   = bit_q + 3'd1;
						cmd_d   = tx_q[1];
						phase_d = PH_CMD;
					end
				end
			end
			default: begin
				if (tick.start_poll) begin
					att_d   = 1'b0;
					byte_d  = 3'd0;
					bit_d   = 3'd0;
					wait_d  = 8'd0;
					tx_d    = tx_byte(3'd0);
					rx_d    = 8'd0;
					phase_d = PH_SETUP;
				end
			end
		endcase
	end

	always_comb begin
		res.clock_level     = clk_d;
		res.command_level   = cmd_d;
		res.attention_level = att_d;
		res.busy_res        = (phase_d != PH_IDLE);
		res.poll_done       = done;
		res.button_word     = btn_d;
		res.pad_type        = type_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			byte_q   <= 3'd0;
			bit_q    <= 3'd0;
			wait_q   <= 8'd0;
			tx_q     <= 8'd0;
			rx_q     <= 8'd0;
			lowbtn_q <= 8'hFF;
			btn_q    <= 16'hFFFF;
			type_q   <= 8'd0;
			clk_q    <= 1'b1;
			cmd_q    <= 1'b1;
			att_q    <= 1'b1;
		end else if (step) begin
			phase_q  <= phase_d;
			byte_q   <= byte_d;
			bit_q    <= bit_d;
			wait_q   <= wait_d;
			tx_q     <= tx_d;
			rx_q     <= rx_d;
			lowbtn_q <= lowbtn_d;
			btn_q    <= btn_d;
			type_q   <= type_d;
			clk_q    <= clk_d;
			cmd_q    <= cmd_d;
			att_q    <= att_d;
		end
	end

	a_att_busy: assert property (@(posedge clk) disable iff (!arst_n)
		att_q == (phase_q == PH_IDLE))
		else $error("attention out of step with phase");

	a_clk_low: assert property (@(posedge clk) disable iff (!arst_n)
		!clk_q |-> phase_q == PH_LOW)
		else $error("clock low outside low half period");

	a_byte_rng: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q <= LAST_BYTE)
		else $error("byte index past last byte");

	a_bit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q != 3'd0 |-> phase_q != PH_IDLE)
		else $error("bit index left set while idle");

endmodule

// ===== src/psx_pad_poll_master_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psx_pad_poll_master_unit
// Pin-level poll master for a game-pad serial link.
//
// tick_ch: one request per timing tick (start_poll, sampled data_level).
// report_ch: one report per request with the pin drive levels, busy,
//   a one-tick poll_done, the last button word and the pad type byte.
// Config: cfg_we/cfg_index/cfg_data write half period and select setup
//   tick counts; both reset to 100.
// Timing: on acceptance the sequencer state and the report register (or,
//   if that is full and not taken, the skid entry) update together.
//   Throughput: one request per cycle while tick_ch.ready is high.
// A report register plus one skid entry sit on the report side, so one
//   further request is taken while a report waits; tick_ch.ready drops
//   only when both are full.
// Reset: pins idle high, sequencer idle, buttons all ones, type zero,
//   no report pending.
// ----------------------------------------------------------------------------
module psx_pad_poll_master_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ppm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppm_pkg::CFG_DATA_W-1:0] cfg_data,
	ppm_chan_if.sink                       tick_ch,
	ppm_chan_if.source                     report_ch
);
	import ppm_pkg::*;

	logic [CFG_DATA_W-1:0] half_q;
	logic [CFG_DATA_W-1:0] setup_q;
	logic                  accept;
	logic                  take;
	logic                  out_v_q;
	logic                  skid_v_q;
	report_item_t          res;
	report_item_t          out_q;
	report_item_t          skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q  <= TICKS_RESET;
			setup_q <= TICKS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_HALF_PERIOD)
				half_q <= cfg_data;
			else if (cfg_index == REG_SELECT_SETUP)
				setup_q <= cfg_data;
		end
	end

	assign tick_ch.ready = !skid_v_q;
	assign accept        = tick_ch.valid && !skid_v_q;
	assign take          = out_v_q && report_ch.ready;

	ppm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.tick        (tick_ch.payload),
		.half_ticks  (half_q),
		.setup_ticks (setup_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			if (!out_v_q || take)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (take) begin
			if (skid_v_q)
				skid_v_q <= 1'b0;
			else
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_v_q || take)
				out_q <= res;
			else
				skid_q <= res;
		end else if (take && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign report_ch.valid   = out_v_q;
	assign report_ch.payload = out_q;

	a_skid_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with report register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !report_ch.ready))
		else $error("skid filled while report register drained");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !report_ch.ready |=> skid_v_q && out_v_q)
		else $error("pending report lost under stall");

endmodule
